### sv/alu8_pkg.sv
// ----------------------------------------------------------------------------
// alu8_pkg: shared types and constants for the SM83-style 8-bit ALU
// Action codes, flag layout, beat payload structs and DAA constants.
// ----------------------------------------------------------------------------
package alu8_pkg;

    typedef enum logic [4:0] {
        ACT_ADD   = 5'd0,
        ACT_ADC   = 5'd1,
        ACT_SUB   = 5'd2,
        ACT_SBC   = 5'd3,
        ACT_AND   = 5'd4,
        ACT_OR    = 5'd5,
        ACT_XOR   = 5'd6,
        ACT_CP    = 5'd7,
        ACT_INC   = 5'd8,
        ACT_DEC   = 5'd9,
        ACT_DAA   = 5'd10,
        ACT_CPL   = 5'd11,
        ACT_CCF   = 5'd12,
        ACT_SCF   = 5'd13,
        ACT_RLC   = 5'd14,
        ACT_RL    = 5'd15,
        ACT_RRC   = 5'd16,
        ACT_RR    = 5'd17,
        ACT_SLA   = 5'd18,
        ACT_SRA   = 5'd19,
        ACT_SRL   = 5'd20,
        ACT_SWAP  = 5'd21,
        ACT_BIT   = 5'd22,
        ACT_SET   = 5'd23,
        ACT_RES   = 5'd24,
        ACT_ADD16 = 5'd25
    } alu_act_t;

    localparam int ACT_W    = 5;
    localparam int WORD_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int BIDX_W   = 3;
    localparam int S_DATA_W = 40;  // 16 + 16 + 3 = 35, padded to bytes
    localparam int M_DATA_W = 24;  // 16 + 4 = 20, padded to bytes

    localparam logic [7:0] DAA_LIMIT  = 8'h99;
    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [3:0] NIB_LIMIT  = 4'h9;
    localparam logic [3:0] NIB_MAX    = 4'hF;

    // packed: zero in bit 3 down to carry in bit 0
    typedef struct packed {
        logic zero;
        logic subtract;
        logic half_carry;
        logic carry;
    } alu_flags_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
        logic [BIDX_W-1:0] bit_index;
    } alu_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] result;
        alu_flags_t        flags;
    } alu_res_t;

endpackage

### sv/alu8_in_reg.sv
// ----------------------------------------------------------------------------
// alu8_in_reg: input register stage
// Captures one slave beat; holds it until the execute stage moves it on.
// ----------------------------------------------------------------------------
module alu8_in_reg
    import alu8_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  alu_item_t s_item,
    input  logic      advance,
    output logic      item_valid,
    output alu_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    alu_item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### sv/alu8_exec.sv
// ----------------------------------------------------------------------------
// alu8_exec: single-pass ALU datapath
// Result and next flags from one registered item and the current flags.
// ----------------------------------------------------------------------------
module alu8_exec
    import alu8_pkg::*;
(
    input  alu_item_t  item,
    input  alu_flags_t flags_in,
    output alu_res_t   res
);

    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] bmask;
    logic              cin;
    logic              c_use;
    logic [8:0]        sum9;
    logic [4:0]        hsum5;
    logic [8:0]        dif9;
    logic [4:0]        hdif5;
    logic [16:0]       sum17;
    logic [12:0]       hsum13;
    logic              daa_hi;
    logic              daa_lo;
    logic [BYTE_W-1:0] daa_r;
    logic [BYTE_W-1:0] r8;
    logic [WORD_W-1:0] r16;
    alu_flags_t        nf;
    logic              use_r16;

    assign a     = item.operand_a[BYTE_W-1:0];
    assign b     = item.operand_b[BYTE_W-1:0];
    assign cin   = flags_in.carry;
    assign bmask = BYTE_W'(1) << item.bit_index;
    assign c_use = (item.action == ACT_ADC || item.action == ACT_SBC) ? cin : 1'b0;

    assign sum9   = {1'b0, a} + {1'b0, b} + {8'd0, c_use};
    assign hsum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, c_use};
    assign dif9   = {1'b0, a} - {1'b0, b} - {8'd0, c_use};
    assign hdif5  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, c_use};
    assign sum17  = {1'b0, item.operand_a} + {1'b0, item.operand_b};
    assign hsum13 = {1'b0, item.operand_a[11:0]} + {1'b0, item.operand_b[11:0]};

    // decimal adjust: corrections picked from kept flags and pre-adjust A
    always_comb begin
        if (!flags_in.subtract) begin
            daa_hi = cin || (a > DAA_LIMIT);
            daa_lo = flags_in.half_carry || (a[3:0] > NIB_LIMIT);
            daa_r  = a + (daa_hi ? DAA_HI_ADJ : 8'd0) + (daa_lo ? DAA_LO_ADJ : 8'd0);
        end else begin
            daa_hi = cin;
            daa_lo = flags_in.half_carry;
            daa_r  = a - (daa_hi ? DAA_HI_ADJ : 8'd0) - (daa_lo ? DAA_LO_ADJ : 8'd0);
        end
    end

    always_comb begin
        r8      = '0;
        r16     = '0;
        use_r16 = 1'b0;
        nf      = flags_in;
        case (item.action)
            ACT_ADD, ACT_ADC: begin
                r8 = sum9[7:0];
                nf = '{zero: 1'b0, subtract: 1'b0, half_carry: hsum5[4], carry: sum9[8]};
            end
            ACT_SUB, ACT_SBC, ACT_CP: begin
                r8 = dif9[7:0];
                nf = '{zero: 1'b0, subtract: 1'b1, half_carry: hdif5[4], carry: dif9[8]};
                if (item.action == ACT_CP) begin
                    r16     = item.operand_a;
                    use_r16 = 1'b1;
                end
            end
            ACT_AND: begin
                r8 = a & b;
                nf = '{zero: 1'b0, subtract: 1'b0, half_carry: 1'b1, carry: 1'b0};
            end
            ACT_OR: begin
                r8 = a | b;
                nf = '0;
            end
            ACT_XOR: begin
                r8 = a ^ b;
                nf = '0;
            end
            ACT_INC: begin
                r8 = a + 8'd1;
                nf = '{zero: 1'b0, subtract: 1'b0, half_carry: (a[3:0] == NIB_MAX),
                       carry: cin};
            end
            ACT_DEC: begin
                r8 = a - 8'd1;
                nf = '{zero: 1'b0, subtract: 1'b1, half_carry: (a[3:0] == 4'd0),
                       carry: cin};
            end
            ACT_DAA: begin
                r8 = daa_r;
                nf = '{zero: 1'b0, subtract: flags_in.subtract, half_carry: 1'b0,
                       carry: daa_hi};
            end
            ACT_CPL: begin
                r8 = ~a;
                nf = '{zero: flags_in.zero, subtract: 1'b1, half_carry: 1'b1, carry: cin};
            end
            ACT_CCF: begin
                r8 = a;
                nf = '{zero: flags_in.zero, subtract: 1'b0, half_carry: 1'b0, carry: !cin};
            end
            ACT_SCF: begin
                r8 = a;
                nf = '{zero: flags_in.zero, subtract: 1'b0, half_carry: 1'b0, carry: 1'b1};
            end
            ACT_RLC: begin
                r8 = {a[6:0], a[7]};
                nf = '{zero: 1'b0, subtract: 1'b0, half_carry: 1'b0, carry: a[7]};
            end
            ACT_RL: begin
                r8 = {a[6:0], cin};
                nf = '{zero: 1'b0, subtract: 1'b0, half_carry: 1'b0, carry: a[7]};
            end
            ACT_RRC: begin
                r8 = {a[0], a[7:1]};
                nf = '{zero: 1'b0, subtract: 1'b0, half_carry: 1'b0, carry: a[0]};
            end
            ACT_RR: begin
                r8 = {cin, a[7:1]};
                nf = '{zero: 1'b0, subtract: 1'b0, half_carry: 1'b0, carry: a[0]};
            end
            ACT_SLA: begin
                r8 = {a[6:0], 1'b0};
                nf = '{zero: 1'b0, subtract: 1'b0, half_carry: 1'b0, carry: a[7]};
            end
            ACT_SRA: begin
                r8 = {a[7], a[7:1]};
                nf = '{zero: 1'b0, subtract: 1'b0, half_carry: 1'b0, carry: a[0]};
            end
            ACT_SRL: begin
                r8 = {1'b0, a[7:1]};
                nf = '{zero: 1'b0, subtract: 1'b0, half_carry: 1'b0, carry: a[0]};
            end
            ACT_SWAP: begin
                r8 = {a[3:0], a[7:4]};
                nf = '0;
            end
            ACT_BIT: begin
                r16     = item.operand_a;
                use_r16 = 1'b1;
                nf = '{zero: ((a & bmask) == 8'd0), subtract: 1'b0, half_carry: 1'b1,
                       carry: cin};
            end
            ACT_SET: begin
                r8 = a | bmask;
            end
            ACT_RES: begin
                r8 = a & ~bmask;
            end
            ACT_ADD16: begin
                r16     = sum17[15:0];
                use_r16 = 1'b1;
                nf = '{zero: flags_in.zero, subtract: 1'b0, half_carry: hsum13[12],
                       carry: sum17[16]};
            end
            default: begin
                r8 = '0;
                nf = flags_in;
            end
        endcase

        // zero from the byte result, for the actions that define it that way
        case (item.action)
            ACT_ADD, ACT_ADC, ACT_SUB, ACT_SBC, ACT_CP, ACT_AND, ACT_OR, ACT_XOR,
            ACT_INC, ACT_DEC, ACT_DAA, ACT_RLC, ACT_RL, ACT_RRC, ACT_RR,
            ACT_SLA, ACT_SRA, ACT_SRL, ACT_SWAP: begin
                nf.zero = (r8 == 8'd0);
            end
            default: begin
                nf.zero = nf.zero;
            end
        endcase
    end

    assign res.result = use_r16 ? r16 : {8'd0, r8};
    assign res.flags  = nf;

endmodule

### sv/alu8_out_reg.sv
// ----------------------------------------------------------------------------
// alu8_out_reg: result register stage
// Holds one finished result beat until the master side takes it.
// ----------------------------------------------------------------------------
module alu8_out_reg
    import alu8_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     load,
    input  alu_res_t res_in,
    output logic     m_tvalid,
    input  logic     m_tready,
    output alu_res_t res_out
);

    logic     valid_reg;
    logic     valid_next;
    alu_res_t res_reg;

    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign res_out  = res_reg;

endmodule

### sv/eight_bit_alu_with_flags_core.sv
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_core: SM83-style 8-bit ALU with kept flags
// Input register, single-pass ALU, result register; flags kept in between.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                       | tuser
//  --------+-----+------------------------------------------+-------------
//  s_      | in  | operand_a, operand_b, bit_index, pad     | action[4:0]
//  m_      | out | result, zero, subtract, half, carry, pad | -
//
//  One beat per cycle sustained while the master side takes results; an accepted
//  beat passes the input register, then the result register, to master valid.
//  The flag register updates as an item moves into the result register, so
//  back-to-back beats chain flags without bubbles.
//  Reset (aresetn low, synchronous) clears both stage valids and all flags.
//  A master stall holds the result; the input register takes a beat while it
//  is empty or while its item moves on, so the slave side stalls once it is full.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_flags_core
    import alu8_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // operand_a[15:0], operand_b[31:16],
                                          // bit_index[34:32], zero pad
    input  logic [ACT_W-1:0]    s_tuser,  // action[4:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // result[15:0], zero_out[16],
                                          // subtract_out[17], half_carry_out[18],
                                          // carry_out[19], zero pad
);

    alu_item_t  s_item;
    alu_item_t  item;
    logic       item_valid;
    logic       advance;
    alu_res_t   exec_res;
    alu_res_t   out_res;
    alu_flags_t flags_reg;
    alu_flags_t flags_next;

    // unpack slave beat
    assign s_item.action    = s_tuser;
    assign s_item.operand_a = s_tdata[15:0];
    assign s_item.operand_b = s_tdata[31:16];
    assign s_item.bit_index = s_tdata[34:32];

    // item leaves the input register when the result slot is free or draining
    assign advance = item_valid && (!m_tvalid || m_tready);

    alu8_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    alu8_exec u_exec (
        .item     (item),
        .flags_in (flags_reg),
        .res      (exec_res)
    );

    // kept flags: commit in item order
    assign flags_next = advance ? exec_res.flags : flags_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else begin
            flags_reg <= flags_next;
        end
    end

    alu8_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .res_in   (exec_res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .res_out  (out_res)
    );

    assign m_tdata = {4'd0, out_res.flags.carry, out_res.flags.half_carry,
                      out_res.flags.subtract, out_res.flags.zero, out_res.result};

    // ---------------------------------------------------------------- checks
    // the newest result shown always carries the flags now kept
    a_flags_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_res.flags == flags_reg))
        else $error("output flags differ from kept flags");

    // a full input stage behind a stalled result must block the slave side
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && m_tvalid && !m_tready) |-> !s_tready)
        else $error("slave ready while both stages are full and stalled");

    // an advancing item always shows up as a valid result next cycle
    a_advance_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("advanced item did not reach the result register");

    // kept flags move only when an item advances
    a_flags_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(flags_reg))
        else $error("flags changed without an item");

endmodule
